FILE: design/hec_pkg.sv
package hec_pkg;

  localparam int MAX_DATA = 57;
  localparam int MAX_CODE = 63;
  localparam int WORD_W   = 63;
  localparam int DL_W     = 6;
  localparam int SYN_W    = 6;
  localparam int CHK_W    = 3;

  localparam logic [DL_W-1:0] DL_RESET = DL_W'(4);

  typedef enum logic {
    OP_ENCODE = 1'b0,
    OP_DECODE = 1'b1
  } op_e;

  typedef struct packed {
    logic [CHK_W-1:0]    r;
    logic [SYN_W-1:0]    n;
    logic [MAX_DATA-1:0] dmask;
    logic [WORD_W-1:0]   cmask;
  } cfg_t;

  function automatic logic [CHK_W-1:0] check_count(input logic [DL_W-1:0] a);
    logic [CHK_W-1:0] r;
    r = '0;
    for (int j = 0; j < SYN_W; j++) begin
      if (((7'd1 << r) - {4'b0, r} - 7'd1) < {1'b0, a}) begin
        r = r + CHK_W'(1);
      end
    end
    return r;
  endfunction

  function automatic cfg_t cfg_derive(input logic [DL_W-1:0] dl);
    cfg_t             c;
    logic [DL_W-1:0]  a;
    if (dl == '0) begin
      a = DL_W'(1);
    end else if (dl > DL_W'(MAX_DATA)) begin
      a = DL_W'(MAX_DATA);
    end else begin
      a = dl;
    end
    c.r = check_count(a);
    c.n = a + {3'b0, c.r};
    for (int j = 0; j < MAX_DATA; j++) begin
      c.dmask[j] = (DL_W'(j) < a);
    end
    for (int j = 0; j < WORD_W; j++) begin
      c.cmask[j] = (SYN_W'(j) < c.n);
    end
    return c;
  endfunction

  // code position (1-based) of data bit k: k-th position that is not a power of two
  function automatic int data_pos(input int k);
    int cnt;
    int pos;
    cnt = 0;
    pos = 0;
    for (int p = 1; p <= MAX_CODE; p++) begin
      if ((p & (p - 1)) != 0) begin
        if (cnt == k) begin
          pos = p;
        end
        cnt = cnt + 1;
      end
    end
    return pos;
  endfunction

  function automatic logic [WORD_W-1:0] cover_mask(input int i);
    logic [WORD_W-1:0] m;
    logic [SYN_W-1:0]  pos;
    m = '0;
    for (int j = 0; j < WORD_W; j++) begin
      pos  = SYN_W'(j + 1);
      m[j] = pos[i];
    end
    return m;
  endfunction

endpackage

FILE: design/hamming_encode_correct_top.sv
// Channel  | Handshake                     | Payload
// -------- | ----------------------------- | -------------------------------------------
// input    | in_valid_i / in_stall_o       | op_i, word_in_i
// output   | out_valid_o / out_stall_i     | word_out_o, check_bits_o, syndrome_o,
//          |                               | error_found_o, beyond_length_o
// config   | cfg_we_i (no wait)            | cfg_data_i (data_length)
//
// Three register stages: scatter/mask, syndrome parity trees, correct/insert check bits.
// One beat per cycle is sustained when the output is not stalled.
// Reset clears the stage valid bits and loads data_length 4 (r = 3, n = 7).
// A stall holds the output stage; upstream stages keep filling until each is occupied.
module hamming_encode_correct_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [hec_pkg::DL_W-1:0]       cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           op_i,
  input  logic [hec_pkg::WORD_W-1:0]     word_in_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [hec_pkg::WORD_W-1:0]     word_out_o,
  output logic [hec_pkg::CHK_W-1:0]      check_bits_o,
  output logic [hec_pkg::SYN_W-1:0]      syndrome_o,
  output logic                           error_found_o,
  output logic                           beyond_length_o
);

  hec_pkg::cfg_t cfg_q;

  logic s1_valid_q, s2_valid_q, s3_valid_q;
  logic s1_ready, s2_ready, s3_ready;

  hec_pkg::op_e                   s1_op_q, s2_op_q;
  logic [hec_pkg::WORD_W-1:0]     s1_cw_q, s2_cw_q;
  logic [hec_pkg::WORD_W-1:0]     s1_cw_d;
  logic [hec_pkg::SYN_W-1:0]      s2_syn_q, s2_syn_d;

  logic [hec_pkg::WORD_W-1:0]     s3_word_q, s3_word_d;
  logic [hec_pkg::SYN_W-1:0]      s3_syn_q, s3_syn_d;
  logic                           s3_err_q, s3_err_d;
  logic                           s3_beyond_q, s3_beyond_d;

  logic [hec_pkg::MAX_DATA-1:0]   data_m;
  logic [hec_pkg::WORD_W-1:0]     scat;
  logic [hec_pkg::WORD_W-1:0]     flip;
  logic                           syn_beyond;

  // config
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= hec_pkg::cfg_derive(hec_pkg::DL_RESET);
    end else if (cfg_we_i) begin
      cfg_q <= hec_pkg::cfg_derive(cfg_data_i);
    end
  end

  // elastic handshake
  assign s3_ready   = !s3_valid_q || !out_stall_i;
  assign s2_ready   = !s2_valid_q || s3_ready;
  assign s1_ready   = !s1_valid_q || s2_ready;
  assign in_stall_o = !s1_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid_q <= in_valid_i;
      end
      if (s2_ready) begin
        s2_valid_q <= s1_valid_q;
      end
      if (s3_ready) begin
        s3_valid_q <= s2_valid_q;
      end
    end
  end

  // stage 1: scatter data bits or mask codeword
  assign data_m = word_in_i[hec_pkg::MAX_DATA-1:0] & cfg_q.dmask;

  for (genvar k = 0; k < hec_pkg::MAX_DATA; k++) begin : g_scat
    localparam int Pos = hec_pkg::data_pos(k);
    assign scat[Pos-1] = data_m[k];
  end
  for (genvar i = 0; i < hec_pkg::SYN_W; i++) begin : g_chk0
    assign scat[(1 << i) - 1] = 1'b0;
  end

  always_comb begin
    if (op_i == hec_pkg::OP_DECODE) begin
      s1_cw_d = word_in_i & cfg_q.cmask;
    end else begin
      s1_cw_d = scat;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_ready && in_valid_i) begin
      s1_op_q <= hec_pkg::op_e'(op_i);
      s1_cw_q <= s1_cw_d;
    end
  end

  // stage 2: syndrome
  always_comb begin
    for (int i = 0; i < hec_pkg::SYN_W; i++) begin
      s2_syn_d[i] = ^(s1_cw_q & hec_pkg::cover_mask(i));
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_ready && s1_valid_q) begin
      s2_op_q  <= s1_op_q;
      s2_cw_q  <= s1_cw_q;
      s2_syn_q <= s2_syn_d;
    end
  end

  // stage 3: insert check bits or correct
  assign syn_beyond = (s2_syn_q > cfg_q.n);

  always_comb begin
    for (int j = 0; j < hec_pkg::WORD_W; j++) begin
      flip[j] = (s2_syn_q == hec_pkg::SYN_W'(j + 1)) && !syn_beyond;
    end
  end

  always_comb begin
    s3_word_d   = s2_cw_q;
    s3_syn_d    = '0;
    s3_err_d    = 1'b0;
    s3_beyond_d = 1'b0;
    unique case (s2_op_q)
      hec_pkg::OP_ENCODE: begin
        for (int i = 0; i < hec_pkg::SYN_W; i++) begin
          s3_word_d[(1 << i) - 1] = s2_syn_q[i];
        end
      end
      hec_pkg::OP_DECODE: begin
        s3_word_d   = s2_cw_q ^ flip;
        s3_syn_d    = s2_syn_q;
        s3_err_d    = (s2_syn_q != '0);
        s3_beyond_d = syn_beyond;
      end
      default: begin
        s3_word_d = s2_cw_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (s3_ready && s2_valid_q) begin
      s3_word_q   <= s3_word_d;
      s3_syn_q    <= s3_syn_d;
      s3_err_q    <= s3_err_d;
      s3_beyond_q <= s3_beyond_d;
    end
  end

  assign out_valid_o     = s3_valid_q;
  assign word_out_o      = s3_word_q;
  assign check_bits_o    = cfg_q.r;
  assign syndrome_o      = s3_syn_q;
  assign error_found_o   = s3_err_q;
  assign beyond_length_o = s3_beyond_q;

  a_beyond_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && beyond_length_o |-> error_found_o)
    else $error("beyond_length without error_found");

  a_err_syn: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (error_found_o == (syndrome_o != '0)))
    else $error("error_found disagrees with syndrome");

  a_word_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((word_out_o & ~cfg_q.cmask) == '0))
    else $error("word_out has bits beyond code length");

  a_beyond_cmp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && beyond_length_o |-> (syndrome_o > cfg_q.n))
    else $error("beyond_length with syndrome inside code");

  a_stall_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_valid_q && s2_valid_q && s3_valid_q && out_stall_i))
    else $error("input stalled while a stage is free");

endmodule

FILE: tb/sv/hamming_encode_correct_top_tb.sv
module hamming_encode_correct_top_tb;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 8;
  localparam int REPORT_MAX = 10;

  typedef struct {
    logic [hec_pkg::WORD_W-1:0] word;
    logic [hec_pkg::CHK_W-1:0]  chk;
    logic [hec_pkg::SYN_W-1:0]  syn;
    logic                       err;
    logic                       beyond;
  } hec_result_t;

  typedef enum int {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_mode_e;

  logic                       clk;
  logic                       rst_n = 1'b0;
  logic                       cfg_we = 1'b0;
  logic [hec_pkg::DL_W-1:0]   cfg_data = '0;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  hec_pkg::op_e               op_in = hec_pkg::OP_ENCODE;
  logic [hec_pkg::WORD_W-1:0] word_in = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic [hec_pkg::WORD_W-1:0] word_out;
  logic [hec_pkg::CHK_W-1:0]  check_bits;
  logic [hec_pkg::SYN_W-1:0]  syndrome;
  logic                       error_found;
  logic                       beyond_length;

  logic [hec_pkg::DL_W-1:0]   data_len = hec_pkg::DL_RESET;
  hec_result_t                hamming_due[$];
  int                         failures = 0;
  int                         cycles = 0;
  int                         burst_left = 0;

  hamming_encode_correct_top i_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_data_i      (cfg_data),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .op_i            (op_in),
    .word_in_i       (word_in),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .word_out_o      (word_out),
    .check_bits_o    (check_bits),
    .syndrome_o      (syndrome),
    .error_found_o   (error_found),
    .beyond_length_o (beyond_length)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic void code_shape(output int a, output int r, output int n);
    a = int'(data_len);
    if (a < 1) a = 1;
    if (a > hec_pkg::MAX_DATA) a = hec_pkg::MAX_DATA;
    r = 0;
    while (r < 6 && ((1 << r) - r - 1) < a) r++;
    n = a + r;
    if (n > hec_pkg::MAX_CODE) n = hec_pkg::MAX_CODE;
  endfunction

  function automatic logic [hec_pkg::SYN_W-1:0] position_parity(
      input logic [hec_pkg::WORD_W-1:0] cw, input int n);
    logic [hec_pkg::SYN_W-1:0] s;
    s = '0;
    for (int p = 1; p <= n; p++) begin
      if (cw[p-1]) s ^= hec_pkg::SYN_W'(p);
    end
    return s;
  endfunction

  function automatic hec_result_t hamming_apply(input hec_pkg::op_e op,
                                                input logic [hec_pkg::WORD_W-1:0] w);
    hec_result_t res;
    int a, r, n, k;
    logic [hec_pkg::WORD_W-1:0] cw;
    logic [hec_pkg::SYN_W-1:0]  syn;
    code_shape(a, r, n);
    cw = '0;
    res.err = 1'b0;
    res.beyond = 1'b0;
    if (op == hec_pkg::OP_ENCODE) begin
      k = 0;
      for (int p = 1; p <= n; p++) begin
        if ((p & (p - 1)) != 0) begin
          cw[p-1] = w[k];
          k++;
        end
      end
      syn = position_parity(cw, n);
      for (int i = 0; i < r; i++) begin
        if (syn[i]) cw[(1 << i) - 1] = 1'b1;
      end
      syn = '0;
    end else begin
      for (int p = 0; p < n; p++) cw[p] = w[p];
      syn = position_parity(cw, n);
      if (syn != '0) begin
        res.err = 1'b1;
        if (int'(syn) > n) res.beyond = 1'b1;
        else cw[int'(syn) - 1] = ~cw[int'(syn) - 1];
      end
    end
    res.word = cw;
    res.chk = hec_pkg::CHK_W'(r);
    res.syn = syn;
    return res;
  endfunction

  function automatic logic [hec_pkg::WORD_W-1:0] rand_word();
    return hec_pkg::WORD_W'({$urandom, $urandom});
  endfunction

  function automatic logic [hec_pkg::WORD_W-1:0] codeword_of(
      input logic [hec_pkg::WORD_W-1:0] data);
    hec_result_t res;
    res = hamming_apply(hec_pkg::OP_ENCODE, data);
    return res.word;
  endfunction

  task automatic note_failure(input string msg);
    failures++;
    if (failures <= REPORT_MAX) $display("%s", msg);
  endtask

  // receiver: stall on a mode that is redrawn at random from time to time
  initial begin
    stall_mode_e mode;
    int left;
    int phase;
    mode = STALL_NONE;
    left = 0;
    phase = 0;
    forever begin
      @(posedge clk);
      if (left == 0) begin
        mode = stall_mode_e'($urandom_range(0, 3));
        left = $urandom_range(16, 200);
      end
      left--;
      phase++;
      case (mode)
        STALL_NONE:     out_stall <= 1'b0;
        STALL_LIGHT:    out_stall <= ($urandom_range(0, 3) == 0);
        STALL_HEAVY:    out_stall <= ($urandom_range(0, 3) != 0);
        STALL_PERIODIC: out_stall <= ((phase % 5) < 2);
        default:        out_stall <= 1'b0;
      endcase
    end
  end

  always @(posedge clk) begin
    hec_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (hamming_due.size() == 0) begin
        note_failure($sformatf("unexpected beat: word %h chk %0d syn %0d err %b beyond %b",
                               word_out, check_bits, syndrome, error_found, beyond_length));
      end else begin
        want = hamming_due.pop_front();
        if (word_out !== want.word || check_bits !== want.chk || syndrome !== want.syn ||
            error_found !== want.err || beyond_length !== want.beyond) begin
          note_failure($sformatf(
            "mismatch: exp word %h chk %0d syn %0d err %b beyond %b / got %h %0d %0d %b %b",
            want.word, want.chk, want.syn, want.err, want.beyond,
            word_out, check_bits, syndrome, error_found, beyond_length));
        end
      end
    end
  end

  task automatic send_beat(input hec_pkg::op_e op, input logic [hec_pkg::WORD_W-1:0] w);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 6) : 0;
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_valid <= 1'b1;
    op_in <= op;
    word_in <= w;
    do @(posedge clk); while (in_stall);
    hamming_due.push_back(hamming_apply(op, w));
  endtask

  task automatic write_length(input logic [hec_pkg::DL_W-1:0] len);
    in_valid <= 1'b0;
    burst_left = 0;
    while (hamming_due.size() != 0) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= len;
    @(posedge clk);
    cfg_we <= 1'b0;
    data_len = len;
  endtask

  task automatic test_reset_length();
    send_beat(hec_pkg::OP_ENCODE, '0);
    send_beat(hec_pkg::OP_ENCODE, '1);
    send_beat(hec_pkg::OP_ENCODE, 63'h5A5A_0000_0000_00BB);
    send_beat(hec_pkg::OP_DECODE, '0);
    send_beat(hec_pkg::OP_DECODE, '1);
    send_beat(hec_pkg::OP_DECODE, codeword_of(63'hB) ^ 63'h10);
  endtask

  task automatic test_length_extremes();
    write_length(hec_pkg::DL_W'(0));
    send_beat(hec_pkg::OP_ENCODE, 63'h1);
    send_beat(hec_pkg::OP_DECODE, 63'h7);
    write_length(hec_pkg::DL_W'(63));
    send_beat(hec_pkg::OP_ENCODE, '1);
    send_beat(hec_pkg::OP_DECODE, codeword_of('1) ^ {1'b1, 62'b0});
    send_beat(hec_pkg::OP_DECODE, '1);
  endtask

  task automatic test_beyond_length();
    write_length(hec_pkg::DL_W'(5));
    send_beat(hec_pkg::OP_DECODE, 63'h082);
    send_beat(hec_pkg::OP_DECODE, 63'h0C0);
  endtask

  task automatic test_single_errors();
    write_length(hec_pkg::DL_W'(26));
    send_beat(hec_pkg::OP_DECODE, codeword_of(63'h2AB_CDEF) ^ 63'h1);
    send_beat(hec_pkg::OP_DECODE, codeword_of(63'h155_4321) ^ 63'h4000_0000);
  endtask

  task automatic test_random();
    logic [hec_pkg::DL_W-1:0] lens[$];
    logic [hec_pkg::WORD_W-1:0] cw;
    int a, r, n, kind;
    lens = '{6'd1, 6'd2, 6'd3, 6'd4, 6'd11, 6'd26, 6'd57, 6'd0, 6'd63, 6'd5, 6'd40,
             hec_pkg::DL_W'($urandom_range(1, 57)), hec_pkg::DL_W'($urandom_range(0, 63))};
    foreach (lens[li]) begin
      write_length(lens[li]);
      code_shape(a, r, n);
      repeat (100) begin
        kind = $urandom_range(0, 9);
        if (kind < 3) begin
          send_beat(hec_pkg::OP_ENCODE, rand_word());
        end else if (kind < 8) begin
          cw = codeword_of(rand_word());
          repeat ($urandom_range(0, 2)) cw[$urandom_range(0, n - 1)] ^= 1'b1;
          if ($urandom_range(0, 7) == 0) cw |= rand_word() & ~((63'h1 << n) - 63'h1);
          send_beat(hec_pkg::OP_DECODE, cw);
        end else begin
          send_beat(hec_pkg::OP_DECODE, rand_word());
        end
      end
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_length();
    test_length_extremes();
    test_beyond_length();
    test_single_errors();
    test_random();
    in_valid <= 1'b0;
    while (hamming_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (failures == 0 && hamming_due.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
